// ===== rtl/asf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package asf_pkg;

    localparam int unsigned SOURCES = 37;

    localparam int ENGINE_W = 6;
    localparam int SAMPLE_W = 16;
    localparam int OUT_W    = 15;
    localparam int LEVEL_W  = 16;
    localparam int STEP_W   = 24;
    localparam int GAIN_W   = 24;
    localparam int SEED_W   = 32;
    localparam int SCALED_W = 17;
    localparam int PHASE_W  = 2;
    localparam int ADDR_W   = 2;
    localparam int DATA_W   = 32;

    // register byte addresses
    localparam logic [ADDR_W-1:0] ADDR_FADE_STEP = 2'd0;

    localparam logic [ENGINE_W-1:0] ENGINE_LAST = ENGINE_W'(SOURCES - 1);

    localparam logic [GAIN_W-1:0] GAIN_ONE   = 24'd8388608;
    localparam logic [STEP_W-1:0] STEP_RESET = 24'd87;
    localparam logic [STEP_W-1:0] STEP_MIN   = 24'd1;

    localparam logic [8:0] ENV_COEF = 9'd131;

    // LCG seed = seed * A + C, taken mod 2^32
    localparam logic [SEED_W-1:0] SEED_A     = 32'd1664525;
    localparam logic [SEED_W-1:0] SEED_C     = 32'd1013904223;
    localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;
    localparam logic [63:0] SEED_ONE_W   = {32'd0, SEED_RESET} * {32'd0, SEED_A} + {32'd0, SEED_C};
    localparam logic [SEED_W-1:0] SEED_ONE   = SEED_ONE_W[31:0];
    localparam logic [63:0] SEED_TWO_W   = {32'd0, SEED_ONE} * {32'd0, SEED_A} + {32'd0, SEED_C};
    localparam logic [SEED_W-1:0] SEED_TWO   = SEED_TWO_W[31:0];
    localparam logic [63:0] SEED_THREE_W = {32'd0, SEED_TWO} * {32'd0, SEED_A} + {32'd0, SEED_C};
    localparam logic [SEED_W-1:0] SEED_THREE = SEED_THREE_W[31:0];

    // fade_phase output codes
    localparam logic [PHASE_W-1:0] FADE_STEADY = 2'd0;
    localparam logic [PHASE_W-1:0] FADE_DOWN   = 2'd1;
    localparam logic [PHASE_W-1:0] FADE_IN     = 2'd2;

    typedef enum logic [2:0] {
        PH_STEADY = 3'b001,
        PH_OUT    = 3'b010,
        PH_IN     = 3'b100
    } phase_t;

    typedef struct packed {
        logic [ENGINE_W-1:0] engine;
        logic                bank;
        logic                init;
        logic [SEED_W-1:0]   seed;
        logic [PHASE_W-1:0]  phase;
    } meta_t;

    // tanh(k/4) in Q1.12
    function automatic logic [12:0] tanh_entry(input logic [4:0] k);
        logic [12:0] t;
        case (k)
            5'd0:    t = 13'd0;
            5'd1:    t = 13'd1003;
            5'd2:    t = 13'd1893;
            5'd3:    t = 13'd2602;
            5'd4:    t = 13'd3119;
            5'd5:    t = 13'd3475;
            5'd6:    t = 13'd3707;
            5'd7:    t = 13'd3856;
            5'd8:    t = 13'd3949;
            5'd9:    t = 13'd4006;
            5'd10:   t = 13'd4041;
            5'd11:   t = 13'd4063;
            5'd12:   t = 13'd4076;
            5'd13:   t = 13'd4084;
            5'd14:   t = 13'd4089;
            5'd15:   t = 13'd4091;
            5'd16:   t = 13'd4093;
            5'd17:   t = 13'd4094;
            5'd18:   t = 13'd4095;
            5'd19:   t = 13'd4095;
            default: t = 13'd4096;
        endcase
        return t;
    endfunction

    function automatic logic [12:0] tanh_q12(input logic [14:0] d);
        logic [4:0]  idx;
        logic [9:0]  frac;
        logic [12:0] lo;
        logic [12:0] hi;
        logic [9:0]  diff;
        logic [20:0] interp;
        logic [12:0] t;
        idx    = d[14:10];
        frac   = d[9:0];
        lo     = tanh_entry(idx);
        hi     = tanh_entry(idx + 5'd1);
        diff   = 10'(hi - lo);
        interp = {11'd0, diff} * {11'd0, frac} + 21'd512;
        if (idx >= 5'd20)
        begin
            t = 13'd4096;
        end
        else
        begin
            t = lo + 13'(interp[20:10]);
        end
        return t;
    endfunction

    // unity inside +-1.0, 1 + tanh(|x| - 1) outside
    function automatic logic signed [OUT_W-1:0] soft_limit(input logic signed [SCALED_W-1:0] x);
        logic [14:0]        d;
        logic [13:0]        y;
        logic signed [15:0] ys;
        logic signed [OUT_W-1:0] res;
        d  = '0;
        if (x > 17'sd4096)
        begin
            d = 15'(x - 17'sd4096);
        end
        else if (x < -17'sd4096)
        begin
            d = 15'(-x - 17'sd4096);
        end
        y  = 14'd4096 + 14'(tanh_q12(d));
        ys = $signed({2'b00, y});
        if (x > 17'sd4096)
        begin
            res = 15'(ys);
        end
        else if (x < -17'sd4096)
        begin
            res = 15'(-ys);
        end
        else
        begin
            res = x[OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/audio_source_switch_fader.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Source-switch fader, one beat per stereo audio sample.
// Input channel (in_valid/in_ready): requested source, requested bank and the
// stereo sample of the source now playing. Output channel (out_valid/out_ready):
// faded, soft-limited sample, peak level, the source and bank now playing, the
// init strobe with its seed, and the fade phase.
// fade_step is to be written over the APB port only while the block is idle; the
// block does not enforce it. pready is always high; prdata returns the register.
// An input beat passes the input register, fade control and state update into
// stage 1, the gain multiply into stage 2, then soft limit and level envelope
// into the output register.
// Throughput is one beat per cycle while the receiver does not stall; the fade
// state and the level envelope are each updated once per beat to keep that rate.
// Reset clears the pipeline and returns the fader to full gain, steady phase,
// source 0, bank 0 and seed_reg SEED_THREE; the first beat after reset fades
// straight in on the requested source and pulses engine_init with SEED_TWO.
// When the receiver stalls, the output beat holds and the stages behind it keep
// filling until the pipeline is full, after which in_ready drops.
module audio_source_switch_fader (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [asf_pkg::ENGINE_W-1:0]     target_engine,
    input  wire logic                             bank_request,
    input  wire logic signed [asf_pkg::SAMPLE_W-1:0] left_in,
    input  wire logic signed [asf_pkg::SAMPLE_W-1:0] right_in,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic signed [asf_pkg::OUT_W-1:0]      left_out,
    output logic signed [asf_pkg::OUT_W-1:0]      right_out,
    output logic [asf_pkg::LEVEL_W-1:0]           level,
    output logic [asf_pkg::ENGINE_W-1:0]          active_engine,
    output logic                                  active_bank,
    output logic                                  engine_init,
    output logic [asf_pkg::SEED_W-1:0]            init_seed,
    output logic [asf_pkg::PHASE_W-1:0]           fade_phase,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [asf_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [asf_pkg::DATA_W-1:0]       pwdata,
    output logic [asf_pkg::DATA_W-1:0]            prdata,
    output logic                                  pready
);

    // configuration
    logic [asf_pkg::STEP_W-1:0] fade_step_reg;
    logic                       cfg_write;

    // pipeline valid bits and stage enables
    logic v0_reg, v1_reg, v2_reg, vo_reg;
    logic rdy1, rdy2, rdy_o;

    // stage 0: input register
    logic [asf_pkg::ENGINE_W-1:0]        tgt0_reg;
    logic                                bank0_reg;
    logic signed [asf_pkg::SAMPLE_W-1:0] li0_reg, ri0_reg;

    // fade state
    asf_pkg::phase_t              phase_reg, phase_next;
    logic [asf_pkg::GAIN_W-1:0]   gain_reg, gain_next;
    logic [asf_pkg::ENGINE_W-1:0] cur_reg, cur_next;
    logic                         bank_reg, bank_next;
    logic                         first_reg;
    logic [asf_pkg::SEED_W-1:0]   seed_reg, seed_next;

    // stage 1
    logic signed [asf_pkg::SAMPLE_W-1:0] li1_reg, ri1_reg;
    logic [asf_pkg::GAIN_W-1:0]          gain1_reg;
    asf_pkg::meta_t                      meta1_reg, meta_next;

    // stage 2
    logic signed [asf_pkg::SCALED_W-1:0] l2_reg, r2_reg, l_next, r_next;
    asf_pkg::meta_t                      meta2_reg;

    // output stage
    logic signed [asf_pkg::OUT_W-1:0] lo_reg, ro_reg;
    logic [asf_pkg::LEVEL_W-1:0]      env_reg, env_next;
    asf_pkg::meta_t                   meta_o_reg;

    // control combinational signals
    logic [asf_pkg::ENGINE_W-1:0] tgt;
    logic [asf_pkg::STEP_W-1:0]   step;
    logic [asf_pkg::ENGINE_W-1:0] cur_e;
    logic                         bank_e;
    logic [asf_pkg::GAIN_W-1:0]   gain_e;
    asf_pkg::phase_t              phase_e;
    logic signed [25:0]           gain_up, gain_dn;
    logic                         same_req;
    logic                         strobe;
    logic [asf_pkg::SEED_W-1:0]   seed_out;
    logic [asf_pkg::PHASE_W-1:0]  phase_code;

    // gain multiply
    logic signed [40:0] l_prod, r_prod, l_sum, r_sum;

    // envelope
    logic [asf_pkg::SCALED_W-1:0] l_abs, r_abs;
    logic [asf_pkg::LEVEL_W-1:0]  mag;
    logic signed [20:0]           env_diff;
    logic signed [29:0]           env_prod, env_sum;
    logic signed [17:0]           env_new;

    assign pready    = 1'b1;
    assign prdata    = asf_pkg::DATA_W'(fade_step_reg);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_step_reg <= asf_pkg::STEP_RESET;
        end
        else if (cfg_write && (paddr == asf_pkg::ADDR_FADE_STEP))
        begin
            fade_step_reg <= pwdata[asf_pkg::STEP_W-1:0];
        end
    end

    assign rdy_o    = !vo_reg || out_ready;
    assign rdy2     = !v2_reg || rdy_o;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = !v0_reg || rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                v0_reg <= in_valid;
            end
            if (rdy1)
            begin
                v1_reg <= v0_reg;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy_o)
            begin
                vo_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            tgt0_reg  <= target_engine;
            bank0_reg <= bank_request;
            li0_reg   <= left_in;
            ri0_reg   <= right_in;
        end
    end

    // fade control
    always_comb
    begin
        tgt  = (tgt0_reg > asf_pkg::ENGINE_LAST) ? asf_pkg::ENGINE_LAST : tgt0_reg;
        step = (fade_step_reg == '0) ? asf_pkg::STEP_MIN :
               (fade_step_reg > asf_pkg::GAIN_ONE) ? asf_pkg::GAIN_ONE : fade_step_reg;

        // first beat: take the request and fade in from zero
        cur_e   = first_reg ? tgt : cur_reg;
        bank_e  = first_reg ? bank0_reg : bank_reg;
        gain_e  = first_reg ? '0 : gain_reg;
        phase_e = first_reg ? asf_pkg::PH_IN : phase_reg;

        gain_up  = $signed({2'b00, gain_e}) + $signed({2'b00, step});
        gain_dn  = $signed({2'b00, gain_e}) - $signed({2'b00, step});
        same_req = (tgt == cur_e) && (bank0_reg == bank_e);

        strobe     = first_reg;
        seed_out   = first_reg ? asf_pkg::SEED_TWO : '0;
        seed_next  = seed_reg;
        cur_next   = cur_e;
        bank_next  = bank_e;
        gain_next  = gain_e;
        phase_next = phase_e;

        case (phase_e)
            asf_pkg::PH_OUT:
            begin
                if (same_req)
                begin
                    // request came home: abort the switch
                    gain_next  = gain_dn[25] ? '0 : gain_dn[asf_pkg::GAIN_W-1:0];
                    phase_next = asf_pkg::PH_IN;
                end
                else if (gain_dn <= 26'sd0)
                begin
                    gain_next  = '0;
                    cur_next   = tgt;
                    bank_next  = bank0_reg;
                    strobe     = 1'b1;
                    seed_out   = seed_reg;
                    seed_next  = seed_reg * asf_pkg::SEED_A + asf_pkg::SEED_C;
                    phase_next = asf_pkg::PH_IN;
                end
                else
                begin
                    gain_next  = gain_dn[asf_pkg::GAIN_W-1:0];
                    phase_next = asf_pkg::PH_OUT;
                end
            end
            asf_pkg::PH_IN:
            begin
                if (gain_up >= $signed({2'b00, asf_pkg::GAIN_ONE}))
                begin
                    gain_next  = asf_pkg::GAIN_ONE;
                    phase_next = asf_pkg::PH_STEADY;
                end
                else
                begin
                    gain_next  = gain_up[asf_pkg::GAIN_W-1:0];
                    phase_next = asf_pkg::PH_IN;
                end
                if (!same_req)
                begin
                    phase_next = asf_pkg::PH_OUT;
                end
            end
            default:
            begin
                phase_next = same_req ? asf_pkg::PH_STEADY : asf_pkg::PH_OUT;
            end
        endcase

        case (phase_next)
            asf_pkg::PH_OUT: phase_code = asf_pkg::FADE_DOWN;
            asf_pkg::PH_IN:  phase_code = asf_pkg::FADE_IN;
            default:         phase_code = asf_pkg::FADE_STEADY;
        endcase

        meta_next.engine = cur_next;
        meta_next.bank   = bank_next;
        meta_next.init   = strobe;
        meta_next.seed   = seed_out;
        meta_next.phase  = phase_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= asf_pkg::PH_STEADY;
            gain_reg  <= asf_pkg::GAIN_ONE;
            cur_reg   <= '0;
            bank_reg  <= 1'b0;
            first_reg <= 1'b1;
            // next seed to hand out once the first beat has used two
            seed_reg  <= asf_pkg::SEED_THREE;
        end
        else if (rdy1 && v0_reg)
        begin
            phase_reg <= phase_next;
            gain_reg  <= gain_next;
            cur_reg   <= cur_next;
            bank_reg  <= bank_next;
            first_reg <= 1'b0;
            seed_reg  <= seed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            li1_reg   <= li0_reg;
            ri1_reg   <= ri0_reg;
            gain1_reg <= gain_next;
            meta1_reg <= meta_next;
        end
    end

    // gain product, rounded half away from zero
    always_comb
    begin
        l_prod = li1_reg * $signed({1'b0, gain1_reg});
        r_prod = ri1_reg * $signed({1'b0, gain1_reg});
        l_sum  = l_prod + (l_prod[40] ? 41'sd4194303 : 41'sd4194304);
        r_sum  = r_prod + (r_prod[40] ? 41'sd4194303 : 41'sd4194304);
        l_next = l_sum[39:23];
        r_next = r_sum[39:23];
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            l2_reg    <= l_next;
            r2_reg    <= r_next;
            meta2_reg <= meta1_reg;
        end
    end

    // peak envelope
    always_comb
    begin
        l_abs    = l2_reg[16] ? 17'(-l2_reg) : l2_reg;
        r_abs    = r2_reg[16] ? 17'(-r2_reg) : r2_reg;
        mag      = (r_abs > l_abs) ? r_abs[15:0] : l_abs[15:0];
        env_diff = $signed({1'b0, mag, 4'b0000}) - $signed({5'b00000, env_reg});
        env_prod = env_diff * $signed(asf_pkg::ENV_COEF);
        env_sum  = env_prod + (env_prod[29] ? 30'sd32767 : 30'sd32768);
        env_new  = $signed({2'b00, env_reg}) + 18'($signed(env_sum[29:16]));
        if (env_new[17])
        begin
            env_next = '0;
        end
        else if (env_new[16])
        begin
            env_next = '1;
        end
        else
        begin
            env_next = env_new[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_reg <= '0;
        end
        else if (rdy_o && v2_reg)
        begin
            env_reg <= env_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_o)
        begin
            lo_reg     <= asf_pkg::soft_limit(l2_reg);
            ro_reg     <= asf_pkg::soft_limit(r2_reg);
            meta_o_reg <= meta2_reg;
        end
    end

    assign out_valid     = vo_reg;
    assign left_out      = lo_reg;
    assign right_out     = ro_reg;
    assign level         = env_reg;
    assign active_engine = meta_o_reg.engine;
    assign active_bank   = meta_o_reg.bank;
    assign engine_init   = meta_o_reg.init;
    assign init_seed     = meta_o_reg.seed;
    assign fade_phase    = meta_o_reg.phase;

endmodule

`default_nettype wire

// ===== rtl/asf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module asf_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic signed [asf_pkg::OUT_W-1:0]    left_out,
    input wire logic [asf_pkg::ENGINE_W-1:0]        active_engine,
    input wire logic                                engine_init,
    input wire logic [asf_pkg::SEED_W-1:0]          init_seed
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(init_seed))
        else $error("output beat changed while stalled");

    a_seed_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !engine_init |-> init_seed == '0)
        else $error("seed shown without init strobe");

    a_engine_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> active_engine <= asf_pkg::ENGINE_LAST)
        else $error("active engine out of range");

    a_limit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_out <= 15'sd8192) && (left_out >= -15'sd8192))
        else $error("soft limiter output out of range");

endmodule

bind audio_source_switch_fader asf_checker u_asf_checker (.*);

`default_nettype wire
